/* hdl/spo2e_pkg.sv */
// Shared constants and helpers for the SpO2 ratio window estimator.
// No dependencies; imported by every module of the block.
package spo2e_pkg;

	localparam int SAMPLE_W   = 18;
	localparam int WINDOW_DEF = 100;
	localparam int PCT_W      = 7;
	localparam int K_W        = 7;
	localparam int DIG_W      = 8;

	localparam logic [PCT_W-1:0]    SPO2_TOP  = PCT_W'(110);
	localparam logic [9:0]          SLOPE_SQ  = 10'd625;
	localparam logic [SAMPLE_W-1:0] THR_RESET = SAMPLE_W'(50000);

	function automatic logic [2*K_W-1:0] k_square(input logic [K_W-1:0] k);
		k_square = {{K_W{1'b0}}, k} * {{K_W{1'b0}}, k};
	endfunction

endpackage

/* hdl/spo2e_mul.sv */
// Shared iterative multiplier, one 8-bit digit of the b operand per cycle.
// Depends on spo2e_pkg.
module spo2e_mul import spo2e_pkg::*; #(
	parameter int PW = 114,
	parameter int BW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [PW-1:0] prod
);

	logic          run_q;
	logic          done_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] a_sh_q;
	logic [BW-1:0] b_rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			if (b_rem_q[BW-1:DIG_W] == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			a_sh_q  <= a;
			b_rem_q <= b;
		end else if (run_q) begin
			acc_q   <= acc_q + a_sh_q * PW'(b_rem_q[DIG_W-1:0]);
			a_sh_q  <= a_sh_q << DIG_W;
			b_rem_q <= b_rem_q >> DIG_W;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* hdl/spo2_ratio_window_estimator_core.sv */
// Top level of the SpO2 ratio window estimator: sample window memory, running
// totals, sequencer and result register. Depends on spo2e_pkg and spo2e_mul.
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       s_tdata: red_sample, ir_sample
// m_*      out  m_tvalid / m_tready       m_tdata: spo2_percent, spo2_valid, finger_present
// cfg_*    in   cfg_valid / cfg_ready     cfg_data: finger_threshold
//
// The shared multiplier runs eighteen products (eleven plus a seven-step search over k),
// each stepping through the bytes of b up to its last nonzero byte; an invalid estimate
// or a flat red channel skips the search. s_tready is high only while the sequencer is
// idle. The result register holds a finished item while the next one is taken in.
// Reset clears the totals and the window fill flag; unfilled entries read as zero.
module spo2_ratio_window_estimator_core import spo2e_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,   // [17:0] red_sample, [35:18] ir_sample
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // [6:0] spo2_percent, [7] spo2_valid, [8] finger_present
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SAMPLE_W-1:0] cfg_data
);

	localparam int LW  = $clog2(WINDOW);
	localparam int SW  = SAMPLE_W + LW;
	localparam int QW  = 2 * SAMPLE_W + LW;
	localparam int AW  = QW + LW;
	localparam int PW  = AW + 2 * SW + 2 * K_W;
	localparam int BW  = 2 * SW;
	localparam int MW  = 2 * SAMPLE_W;
	localparam logic [LW-1:0] LAST_POS = LW'(WINDOW - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_RUN, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		ST_OR2, ST_NR2, ST_OI2, ST_NI2, ST_SR2, ST_WQR, ST_SI2, ST_WQI,
		ST_ARS, ST_L625, ST_Q, ST_KQ
	} step_t;

	state_t            state_q;
	step_t             step_q;
	logic [MW-1:0]     mem [WINDOW];
	logic [MW-1:0]     rd_q;
	logic [LW-1:0]     pos_q;
	logic              full_q;
	logic              old_ok_q;
	logic [SAMPLE_W-1:0] thr_q;
	logic [SAMPLE_W-1:0] red_q;
	logic [SAMPLE_W-1:0] ir_q;
	logic [SAMPLE_W-1:0] old_r_q;
	logic [SAMPLE_W-1:0] old_i_q;
	logic              finger_q;
	logic [SW-1:0]     sr_q;
	logic [SW-1:0]     si_q;
	logic [QW-1:0]     sqr_q;
	logic [QW-1:0]     sqi_q;
	logic [BW-1:0]     sr2_q;
	logic [BW-1:0]     si2_q;
	logic [AW-1:0]     ar_q;
	logic [AW-1:0]     ai_q;
	logic [PW-1:0]     lhs_q;
	logic [PW-1:0]     q_q;
	logic [K_W-1:0]    j_q;
	logic [K_W-1:0]    bit_q;
	logic [PCT_W-1:0]  res_pct_q;
	logic              res_valid_q;
	logic              start_q;
	logic [PW-1:0]     a_q;
	logic [BW-1:0]     b_q;
	logic              m_tvalid_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic              out_valid_q;
	logic              out_finger_q;

	logic              mul_done;
	logic [PW-1:0]     prod;
	logic              s_acc;
	logic [SAMPLE_W-1:0] s_red;
	logic [SAMPLE_W-1:0] s_ir;
	logic [AW-1:0]     ai_new;
	logic [K_W-1:0]    t_k;
	logic [K_W-1:0]    j_new;
	logic [K_W:0]      k_fin;
	logic              le;
	logic              seq_stop;

	spo2e_mul #(.PW(PW), .BW(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (a_q),
		.b      (b_q),
		.done   (mul_done),
		.prod   (prod)
	);

	assign s_red    = s_tdata[SAMPLE_W-1:0];
	assign s_ir     = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign ai_new = AW'(prod - PW'(si2_q));
	assign t_k    = j_q | bit_q;
	assign le     = (lhs_q <= prod);
	assign j_new  = le ? j_q : t_k;
	assign k_fin  = {1'b0, j_new} + (K_W+1)'(1);

	// last product of an item: no further multiplier start
	assign seq_stop = (step_q == ST_WQI && (sr_q == '0 || si_q == '0 || ai_new == '0)) ||
		(step_q == ST_Q && lhs_q == '0) || (step_q == ST_KQ && bit_q[0]) ||
		(step_q > ST_KQ);

	always_ff @(posedge clk) begin
		if (s_acc) begin
			rd_q       <= mem[pos_q];
			mem[pos_q] <= {s_ir, s_red};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= ST_OR2;
			pos_q        <= '0;
			full_q       <= 1'b0;
			thr_q        <= THR_RESET;
			sr_q         <= '0;
			si_q         <= '0;
			sqr_q        <= '0;
			sqi_q        <= '0;
			start_q      <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			start_q <= (state_q == S_READ) || (state_q == S_RUN && mul_done && !seq_stop);
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						red_q    <= s_red;
						ir_q     <= s_ir;
						finger_q <= (s_ir >= thr_q);
						old_ok_q <= full_q;
						if (pos_q == LAST_POS) begin
							pos_q  <= '0;
							full_q <= 1'b1;
						end else begin
							pos_q <= pos_q + LW'(1);
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					old_r_q <= old_ok_q ? rd_q[SAMPLE_W-1:0] : '0;
					old_i_q <= old_ok_q ? rd_q[MW-1:SAMPLE_W] : '0;
					a_q     <= old_ok_q ? PW'(rd_q[SAMPLE_W-1:0]) : '0;
					b_q     <= old_ok_q ? BW'(rd_q[SAMPLE_W-1:0]) : '0;
					step_q  <= ST_OR2;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (mul_done) begin
						case (step_q)
							ST_OR2: begin
								sqr_q  <= sqr_q - QW'(prod);
								a_q    <= PW'(red_q);
								b_q    <= BW'(red_q);
								step_q <= ST_NR2;
							end
							ST_NR2: begin
								sqr_q  <= sqr_q + QW'(prod);
								sr_q   <= sr_q - SW'(old_r_q) + SW'(red_q);
								a_q    <= PW'(old_i_q);
								b_q    <= BW'(old_i_q);
								step_q <= ST_OI2;
							end
							ST_OI2: begin
								sqi_q  <= sqi_q - QW'(prod);
								a_q    <= PW'(ir_q);
								b_q    <= BW'(ir_q);
								step_q <= ST_NI2;
							end
							ST_NI2: begin
								sqi_q  <= sqi_q + QW'(prod);
								si_q   <= si_q - SW'(old_i_q) + SW'(ir_q);
								a_q    <= PW'(sr_q);
								b_q    <= BW'(sr_q);
								step_q <= ST_SR2;
							end
							ST_SR2: begin
								sr2_q  <= BW'(prod);
								a_q    <= PW'(sqr_q);
								b_q    <= BW'(WINDOW);
								step_q <= ST_WQR;
							end
							ST_WQR: begin
								ar_q   <= AW'(prod - PW'(sr2_q));
								a_q    <= PW'(si_q);
								b_q    <= BW'(si_q);
								step_q <= ST_SI2;
							end
							ST_SI2: begin
								si2_q  <= BW'(prod);
								a_q    <= PW'(sqi_q);
								b_q    <= BW'(WINDOW);
								step_q <= ST_WQI;
							end
							ST_WQI: begin
								ai_q <= ai_new;
								a_q  <= PW'(ar_q);
								b_q  <= si2_q;
								if (sr_q == '0 || si_q == '0 || ai_new == '0) begin
									res_pct_q   <= '0;
									res_valid_q <= 1'b0;
									state_q     <= S_DONE;
								end else begin
									step_q <= ST_ARS;
								end
							end
							ST_ARS: begin
								a_q    <= prod;
								b_q    <= BW'(SLOPE_SQ);
								step_q <= ST_L625;
							end
							ST_L625: begin
								lhs_q  <= prod;
								a_q    <= PW'(ai_q);
								b_q    <= sr2_q;
								step_q <= ST_Q;
							end
							ST_Q: begin
								q_q         <= prod;
								a_q         <= prod;
								j_q         <= '0;
								bit_q       <= {1'b1, {(K_W-1){1'b0}}};
								b_q         <= BW'(k_square({1'b1, {(K_W-1){1'b0}}}));
								res_valid_q <= 1'b1;
								if (lhs_q == '0) begin
									res_pct_q <= SPO2_TOP;
									state_q   <= S_DONE;
								end else begin
									step_q <= ST_KQ;
								end
							end
							ST_KQ: begin
								j_q   <= j_new;
								bit_q <= bit_q >> 1;
								a_q   <= q_q;
								b_q   <= BW'(k_square(j_new | (bit_q >> 1)));
								if (bit_q[0]) begin
									res_pct_q <= (k_fin > (K_W+1)'(SPO2_TOP)) ? '0 :
										PCT_W'((K_W+1)'(SPO2_TOP) - k_fin);
									state_q   <= S_DONE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q   <= 1'b1;
						out_pct_q    <= res_pct_q;
						out_valid_q  <= res_valid_q;
						out_finger_q <= finger_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_finger_q, out_valid_q, out_pct_q};

endmodule

/* verif/tb.sv */
// Self-checking testbench for spo2_ratio_window_estimator_core: directed table,
// then pulse-like, flat, matched and noise sequences; typed table rows carry fixed
// results, all else is checked by a predictor. Depends on spo2e_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import spo2e_pkg::*;

	localparam int WIN = 100;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [PCT_W-1:0] pct;
		logic             ok;
		logic             finger;
	} spo2_res_t;

	typedef struct {
		logic [17:0] red;
		logic [17:0] ir;
		bit          typed;
		spo2_res_t   res;
	} dir_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [17:0] cfg_data = '0;

	spo2_ratio_window_estimator_core #(.WINDOW(WIN)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [17:0] red_hist [WIN];
	logic [17:0] ir_hist [WIN];
	int          hist_pos;
	logic [63:0] red_sum, ir_sum, red_sq_sum, ir_sq_sum;
	logic [17:0] thr;

	spo2_res_t pending_q [$];
	int        errors = 0;
	int        n_in = 0, n_out = 0, n_valid = 0, n_top = 0, n_zero = 0;
	longint    cycles = 0;
	bit        hold_req = 0;
	int        burst_left = 0;

	function automatic spo2_res_t spo2_predict(input logic [17:0] red, input logic [17:0] ir);
		spo2_res_t   r;
		logic [63:0] o_r, o_i, ar, ai;
		logic [127:0] lhs, q;
		o_r = red_hist[hist_pos];
		o_i = ir_hist[hist_pos];
		red_sum = red_sum - o_r + red;
		ir_sum = ir_sum - o_i + ir;
		red_sq_sum = red_sq_sum - o_r * o_r + 64'(red) * 64'(red);
		ir_sq_sum = ir_sq_sum - o_i * o_i + 64'(ir) * 64'(ir);
		red_hist[hist_pos] = red;
		ir_hist[hist_pos] = ir;
		hist_pos = (hist_pos + 1 >= WIN) ? 0 : hist_pos + 1;
		ar = 64'(WIN) * red_sq_sum - red_sum * red_sum;
		ai = 64'(WIN) * ir_sq_sum - ir_sum * ir_sum;
		r.pct = '0;
		r.ok = 0;
		if (red_sum != 0 && ir_sum != 0 && ai != 0) begin
			r.ok = 1;
			lhs = 128'(ar) * 128'(ir_sum * ir_sum) * 128'(625);
			q = 128'(ai) * 128'(red_sum * red_sum);
			for (int k = 0; k <= 110; k++) begin
				if (lhs <= q * 128'(k * k)) begin
					r.pct = PCT_W'(110 - k);
					break;
				end
			end
		end
		r.finger = (ir >= thr);
		return r;
	endfunction

	task automatic send_sample(input logic [17:0] red, input logic [17:0] ir, input bit typed,
			input spo2_res_t res);
		spo2_res_t p;
		int        gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1;
		s_tdata <= {4'b0, ir, red};
		do @(posedge clk); while (!s_tready);
		p = spo2_predict(red, ir);
		pending_q.push_back(typed ? res : p);
		burst_left--;
		n_in++;
	endtask

	task automatic write_threshold(input logic [17:0] v);
		s_tvalid <= 0;
		burst_left = 0;
		wait (pending_q.size() == 0);
		repeat (200) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		thr = v;
	endtask

	task automatic run_random(input int count);
		int          kind, len, dc_r, dc_i, ac_r, ac_i, per;
		logic [17:0] r, i;
		while (count > 0) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(10, 60);
			dc_r = $urandom_range(1000, 200000);
			dc_i = $urandom_range(1000, 200000);
			ac_r = $urandom_range(0, 4000);
			ac_i = $urandom_range(1, 4000);
			per = $urandom_range(4, 30);
			if (kind == 0) len = 110;
			for (int n = 0; n < len && count > 0; n++) begin
				case (kind)
					0: begin
						r = 18'(dc_r);
						i = 18'(dc_i + ((n % per) * ac_i) / per);
					end
					1, 2: begin
						r = 18'($urandom);
						i = 18'($urandom);
					end
					3: begin
						r = 18'(dc_i + ((n % per) * ac_i) / per);
						i = r;
					end
					default: begin
						r = 18'(dc_r + ((n % per) * ac_r) / per + $urandom_range(0, 50));
						i = 18'(dc_i + ((n % per) * ac_i) / per + $urandom_range(0, 50));
					end
				endcase
				send_sample(r, i, 0, '0);
				count--;
			end
		end
	endtask

	// receiver: random stall patterns, plus one long hold-off on request
	initial begin
		int mode;
		forever begin
			if (hold_req) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end
			mode = $urandom_range(0, 3);
			for (int n = $urandom_range(5, 80); n > 0; n--) begin
				case (mode)
					0: m_tready <= 1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= n[2];
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		spo2_res_t e;
		if (m_tvalid && m_tready) begin
			n_out++;
			if (pending_q.size() == 0) begin
				$error("unexpected transfer m_tdata=%h", m_tdata);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (e.ok) n_valid++;
				if (e.ok && e.pct == 110) n_top++;
				if (e.ok && e.pct == 0) n_zero++;
				if (m_tdata[6:0] !== e.pct) begin
					$error("spo2_percent exp %0d got %0d", e.pct, m_tdata[6:0]);
					errors++;
				end
				if (m_tdata[7] !== e.ok) begin
					$error("spo2_valid exp %0d got %0d", e.ok, m_tdata[7]);
					errors++;
				end
				if (m_tdata[8] !== e.finger) begin
					$error("finger_present exp %0d got %0d", e.finger, m_tdata[8]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [$];
		for (int n = 0; n < WIN; n++) begin
			red_hist[n] = '0;
			ir_hist[n] = '0;
		end
		hist_pos = 0;
		red_sum = 0; ir_sum = 0; red_sq_sum = 0; ir_sq_sum = 0;
		thr = THR_RESET;

		rows.push_back('{18'd0, 18'd0, 1, '{7'd0, 1'b0, 1'b0}});
		rows.push_back('{18'h3FFFF, 18'h3FFFF, 1, '{7'd85, 1'b1, 1'b1}});
		rows.push_back('{18'd0, 18'h3FFFF, 0, '0});
		rows.push_back('{18'h3FFFF, 18'd0, 0, '0});
		rows.push_back('{18'd1, 18'd49999, 0, '0});
		rows.push_back('{18'd2, 18'd50000, 0, '0});
		rows.push_back('{18'h2AAAA, 18'h15555, 0, '0});
		rows.push_back('{18'h15555, 18'h2AAAA, 0, '0});
		rows.push_back('{18'd100000, 18'd100000, 0, '0});
		rows.push_back('{18'd100100, 18'd100010, 0, '0});
		rows.push_back('{18'd5, 18'd200000, 0, '0});
		rows.push_back('{18'd200000, 18'd5, 0, '0});
		rows.push_back('{18'd65536, 18'd65535, 0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[n]) send_sample(rows[n].red, rows[n].ir, rows[n].typed, rows[n].res);
		write_threshold(18'd0);
		run_random(200);
		write_threshold(18'h3FFFF);
		hold_req = 1;
		run_random(200);
		write_threshold(18'($urandom));
		run_random(220);
		write_threshold(THR_RESET);
		run_random(200);

		s_tvalid <= 0;
		wait (pending_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("%0d samples in, %0d results (%0d valid, %0d at top, %0d saturated)",
			n_in, n_out, n_valid, n_top, n_zero);
		$display("four threshold settings, one long output hold-off");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* spo2_ratio_window_estimator_core.f */
hdl/spo2e_pkg.sv
hdl/spo2e_mul.sv
hdl/spo2_ratio_window_estimator_core.sv
verif/tb.sv
